// ===== hw/rtl/ray_sphere_intersect_assert.svh =====
// Assertion macros for the ray/sphere intersection block
`ifndef RAY_SPHERE_INTERSECT_ASSERT_SVH
`define RAY_SPHERE_INTERSECT_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication, sampled on clk, off during reset
`define RSI_ASSERT_IMPL(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("rsi: assertion failed");
// next-cycle implication
`define RSI_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("rsi: assertion failed");
`else
`define RSI_ASSERT_IMPL(lbl, pre, post)
`define RSI_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ===== hw/rtl/rsi_pkg.sv =====
// Shared types and constants for the ray/sphere intersection block
package rsi_pkg;
	localparam int DIST_BITS = 31;
	localparam int MUL_CHUNK = 24;
	localparam int CFG_IDX_BITS = 8;

	typedef logic [DIST_BITS-1:0] dist_t;
	typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

	localparam dist_t DIST_MAX = '1;

	localparam cfg_idx_t REG_CENTER_X = 8'd0;
	localparam cfg_idx_t REG_CENTER_Y = 8'd1;
	localparam cfg_idx_t REG_CENTER_Z = 8'd2;
	localparam cfg_idx_t REG_RADIUS   = 8'd3;
endpackage

// ===== hw/rtl/rsi_if.sv =====
// Channel interfaces: ray input, hit result, register write
interface rsi_ray_if #(
	parameter int COORD_BITS = 32
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] origin_x;
	logic signed [COORD_BITS-1:0] origin_y;
	logic signed [COORD_BITS-1:0] origin_z;
	logic signed [COORD_BITS-1:0] dir_x;
	logic signed [COORD_BITS-1:0] dir_y;
	logic signed [COORD_BITS-1:0] dir_z;

	modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		input ready);
	modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		output ready);
endinterface

interface rsi_res_if import rsi_pkg::*;;
	logic  valid;
	logic  ready;
	logic  hit;
	dist_t distance;

	modport source (output valid, hit, distance, input ready);
	modport sink (input valid, hit, distance, output ready);
endinterface

interface rsi_cfg_if import rsi_pkg::*; #(
	parameter int DATA_BITS = 32
);
	logic                 valid;
	logic                 ready;
	cfg_idx_t             index;
	logic [DATA_BITS-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/ray_sphere_intersect.sv =====
// Ray/sphere intersection, fully pipelined, exact fixed point
//
// One ray (origin, direction, signed Q16.16) is accepted every cycle and one
// result comes back per ray, in order. The depth is set by the square root,
// which resolves one root bit per stage (2*COORD_BITS+1 stages), and the
// final divide, one distance bit per stage (31 stages); the dot products and
// the wide discriminant multiply take seven stages ahead of them. With
// V = O - C the pipe forms a = D.D, h = V.D, c = V.V - R*R exactly, then
// disc = h*h - a*c, s = isqrt(disc) and t = floor((-h -/+ s) *
// 2^FRAC_BITS / a), nearer nonnegative root first. A zero direction, a
// negative discriminant or two negative roots give hit=0, distance=0; a
// distance past 2^31-1 saturates. When the result side stalls the whole
// pipe holds, so input ready drops in the same cycle. The center and
// radius registers are written through the cfg channel (always ready);
// write them only while no ray is in flight.
`include "ray_sphere_intersect_assert.svh"

module ray_sphere_intersect import rsi_pkg::*; #(
	parameter int COORD_BITS = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	rsi_cfg_if.sink   cfg,
	rsi_ray_if.sink   ray,
	rsi_res_if.source res
);
	localparam int CW   = COORD_BITS;
	localparam int VW   = CW + 1;        // origin minus center
	localparam int AW   = 2 * CW + 1;    // a, signed view
	localparam int AUW  = 2 * CW;        // a, magnitude
	localparam int HW   = 2 * CW + 2;    // h
	localparam int CCW  = 2 * CW + 3;    // c
	localparam int DW   = 4 * CW + 4;    // discriminant
	localparam int SQW  = 4 * CW + 2;    // nonnegative discriminant
	localparam int RTW  = SQW / 2;       // root
	localparam int NW   = 2 * CW + 3;    // -h -/+ s, signed
	localparam int NUW  = 2 * CW + 2;    // chosen n, nonnegative
	localparam int SHW  = DIST_BITS - FRAC_BITS;
	localparam int SW   = 2 * CW + SHW + 2;
	localparam int NUMW = NUW + FRAC_BITS;
	localparam int DLY  = RTW + 4;       // stage 3 to root select
	localparam int LAT  = RTW + DIST_BITS + 10;

	// pipeline advance: whole pipe moves unless the output holds a result not taken
	logic en;
	logic [LAT-1:0] vld_q;

	assign en        = !vld_q[LAT-1] || res.ready;
	assign ray.ready = en;
	assign res.valid = vld_q[LAT-1];
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], ray.valid};
		end
	end

	// ---- sphere registers ----
	logic signed [CW-1:0] ctr_x_q, ctr_y_q, ctr_z_q;
	logic [CW-2:0]        rad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_x_q <= '0;
			ctr_y_q <= '0;
			ctr_z_q <= '0;
			rad_q   <= (CW-1)'(1) << FRAC_BITS;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_CENTER_X: ctr_x_q <= cfg.data[CW-1:0];
				REG_CENTER_Y: ctr_y_q <= cfg.data[CW-1:0];
				REG_CENTER_Z: ctr_z_q <= cfg.data[CW-1:0];
				REG_RADIUS:   rad_q   <= cfg.data[CW-2:0];
				default: ;    // unknown index: transfer is dropped
			endcase
		end
	end

	// ---- stage 1: V = O - C ----
	logic signed [VW-1:0] v_x_s1, v_y_s1, v_z_s1;
	logic signed [CW-1:0] d_x_s1, d_y_s1, d_z_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			v_x_s1 <= VW'(ray.origin_x) - VW'(ctr_x_q);
			v_y_s1 <= VW'(ray.origin_y) - VW'(ctr_y_q);
			v_z_s1 <= VW'(ray.origin_z) - VW'(ctr_z_q);
			d_x_s1 <= ray.dir_x;
			d_y_s1 <= ray.dir_y;
			d_z_s1 <= ray.dir_z;
		end
	end

	// ---- stage 2: component products ----
	logic signed [2*CW-1:0] dd_x_s2, dd_y_s2, dd_z_s2;
	logic signed [2*CW:0]   vd_x_s2, vd_y_s2, vd_z_s2;
	logic signed [2*CW+1:0] vv_x_s2, vv_y_s2, vv_z_s2;
	logic [2*CW-3:0]        rr_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			dd_x_s2 <= d_x_s1 * d_x_s1;
			dd_y_s2 <= d_y_s1 * d_y_s1;
			dd_z_s2 <= d_z_s1 * d_z_s1;
			vd_x_s2 <= v_x_s1 * d_x_s1;
			vd_y_s2 <= v_y_s1 * d_y_s1;
			vd_z_s2 <= v_z_s1 * d_z_s1;
			vv_x_s2 <= v_x_s1 * v_x_s1;
			vv_y_s2 <= v_y_s1 * v_y_s1;
			vv_z_s2 <= v_z_s1 * v_z_s1;
			rr_s2   <= rad_q * rad_q;
		end
	end

	// ---- stage 3: a, h, c ----
	logic signed [AW-1:0]  a_s3;
	logic signed [HW-1:0]  h_s3;
	logic signed [CCW-1:0] c_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s3 <= AW'(dd_x_s2) + AW'(dd_y_s2) + AW'(dd_z_s2);
			h_s3 <= HW'(vd_x_s2) + HW'(vd_y_s2) + HW'(vd_z_s2);
			c_s3 <= CCW'(vv_x_s2) + CCW'(vv_y_s2) + CCW'(vv_z_s2) - CCW'(rr_s2);
		end
	end

	// ---- stages 4..6: h*h and a*c ----
	logic signed [DW-1:0] hh;
	logic signed [DW-1:0] ac;

	rsi_mul #(.WA(HW), .WB(HW)) u_mul_hh (
		.clk (clk), .en (en), .a (h_s3), .b (h_s3), .p (hh)
	);

	rsi_mul #(.WA(AW), .WB(CCW)) u_mul_ac (
		.clk (clk), .en (en), .a (a_s3), .b (c_s3), .p (ac)
	);

	// a and h ride alongside the multiply and the root
	logic [AUW-1:0]       a_dl_s [DLY];
	logic signed [HW-1:0] h_dl_s [DLY];

	always_ff @(posedge clk) begin
		if (en) begin
			a_dl_s[0] <= a_s3[AUW-1:0];
			h_dl_s[0] <= h_s3;
			for (int k = 1; k < DLY; k++) begin
				a_dl_s[k] <= a_dl_s[k-1];
				h_dl_s[k] <= h_dl_s[k-1];
			end
		end
	end

	// ---- stage 7: discriminant ----
	logic signed [DW-1:0] disc_s7;
	logic                 disc_neg;
	logic [SQW-1:0]       sq_x;

	always_ff @(posedge clk) begin
		if (en) disc_s7 <= hh - ac;
	end

	assign disc_neg = disc_s7[DW-1];
	assign sq_x     = disc_neg ? '0 : disc_s7[SQW-1:0];

	// ---- square root ----
	logic [RTW-1:0] root;
	logic [RTW-1:0] neg_dl_s;

	rsi_isqrt #(.XW(SQW)) u_isqrt (
		.clk (clk), .en (en), .x (sq_x), .root (root)
	);

	always_ff @(posedge clk) begin
		if (en) neg_dl_s <= {neg_dl_s[RTW-2:0], disc_neg};
	end

	// ---- root select: near root if nonnegative, else far root ----
	logic signed [NW-1:0] nh, s_ext, n_near, n_far;
	logic [AUW-1:0]       a_c;
	logic [NUW-1:0]       n_sc;
	logic [AUW-1:0]       a_sc;
	logic                 hit_sc;

	assign a_c    = a_dl_s[DLY-1];
	assign nh     = -(NW'(h_dl_s[DLY-1]));
	assign s_ext  = NW'(root);
	assign n_near = nh - s_ext;
	assign n_far  = nh + s_ext;

	always_ff @(posedge clk) begin
		if (en) begin
			hit_sc <= !neg_dl_s[RTW-1] && (a_c != '0) &&
				(!n_near[NW-1] || !n_far[NW-1]);
			n_sc   <= n_near[NW-1] ? n_far[NUW-1:0] : n_near[NUW-1:0];
			a_sc   <= a_c;
		end
	end

	// ---- divide setup: saturation check, leading remainder ----
	logic [NUMW-1:0] num;
	logic [AUW-1:0]  rem0_sd, dv_sd;
	dist_t           lo_sd;
	logic            hit_sd, sat_sd;

	assign num = {n_sc, {FRAC_BITS{1'b0}}};

	// quotient fits 31 bits unless n >= a * 2^(31-FRAC_BITS)
	always_ff @(posedge clk) begin
		if (en) begin
			sat_sd  <= SW'(n_sc) >= (SW'(a_sc) << SHW);
			hit_sd  <= hit_sc;
			rem0_sd <= AUW'(num >> DIST_BITS);
			lo_sd   <= num[DIST_BITS-1:0];
			dv_sd   <= a_sc;
		end
	end

	// ---- divide ----
	dist_t                quo;
	logic [DIST_BITS-1:0] hit_dl_s, sat_dl_s;

	rsi_div #(.DW(AUW)) u_div (
		.clk (clk), .en (en), .rem0 (rem0_sd), .lo (lo_sd), .dvs (dv_sd), .quo (quo)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			hit_dl_s <= {hit_dl_s[DIST_BITS-2:0], hit_sd};
			sat_dl_s <= {sat_dl_s[DIST_BITS-2:0], sat_sd};
		end
	end

	// ---- output register ----
	logic  hit_q;
	dist_t dist_q;

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q  <= hit_dl_s[DIST_BITS-1];
			dist_q <= !hit_dl_s[DIST_BITS-1] ? '0 :
				sat_dl_s[DIST_BITS-1] ? DIST_MAX : quo;
		end
	end

	assign res.hit      = hit_q;
	assign res.distance = dist_q;

	// ---- checks ----
	`RSI_ASSERT_IMPL(a_stall_blocks_input, res.valid && !res.ready, !ray.ready)
	`RSI_ASSERT_IMPL(a_miss_zero_distance, res.valid && !res.hit, res.distance == '0)
	`RSI_ASSERT_NEXT(a_transfer_enters_pipe, ray.valid && ray.ready, vld_q[0])
endmodule

// ===== hw/rtl/rsi_mul.sv =====
// Pipelined wide signed multiplier: chunked partial products, row sums, final sum
module rsi_mul import rsi_pkg::*; #(
	parameter int WA = 66,
	parameter int WB = 66
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic signed [WA-1:0]   a,
	input  logic signed [WB-1:0]   b,
	output logic signed [WA+WB-1:0] p
);
	localparam int CH  = MUL_CHUNK;
	localparam int NA  = (WA + CH - 1) / CH;
	localparam int NB  = (WB + CH - 1) / CH;
	localparam int PW  = WA + WB;
	localparam int PPW = 2 * CH + 2;

	logic signed [NA*CH-1:0] a_ext;
	logic signed [NB*CH-1:0] b_ext;
	logic signed [CH:0]      a_ch [NA];
	logic signed [CH:0]      b_ch [NB];
	logic signed [PPW-1:0]   pp_s1 [NA][NB];
	logic signed [PW-1:0]    row_c [NA];
	logic signed [PW-1:0]    row_s2 [NA];
	logic signed [PW-1:0]    sum_c;
	logic signed [PW-1:0]    p_s3;

	assign a_ext = (NA*CH)'(a);
	assign b_ext = (NB*CH)'(b);

	// low chunks are unsigned digits, the top chunk carries the sign
	always_comb begin
		for (int i = 0; i < NA; i++) begin
			if (i == NA - 1) a_ch[i] = {a_ext[NA*CH-1], a_ext[i*CH +: CH]};
			else a_ch[i] = {1'b0, a_ext[i*CH +: CH]};
		end
		for (int j = 0; j < NB; j++) begin
			if (j == NB - 1) b_ch[j] = {b_ext[NB*CH-1], b_ext[j*CH +: CH]};
			else b_ch[j] = {1'b0, b_ext[j*CH +: CH]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NA; i++)
				for (int j = 0; j < NB; j++)
					pp_s1[i][j] <= a_ch[i] * b_ch[j];
		end
	end

	always_comb begin
		for (int i = 0; i < NA; i++) begin
			row_c[i] = '0;
			for (int j = 0; j < NB; j++)
				row_c[i] = row_c[i] + (PW'(pp_s1[i][j]) <<< (CH * j));
		end
	end

	always_ff @(posedge clk) begin
		if (en) row_s2 <= row_c;
	end

	always_comb begin
		sum_c = '0;
		for (int i = 0; i < NA; i++)
			sum_c = sum_c + (row_s2[i] <<< (CH * i));
	end

	always_ff @(posedge clk) begin
		if (en) p_s3 <= sum_c;
	end

	assign p = p_s3;
endmodule

// ===== hw/rtl/rsi_isqrt.sv =====
// Pipelined integer square root, one root bit per stage
module rsi_isqrt #(
	parameter int XW = 130
) (
	input  logic            clk,
	input  logic            en,
	input  logic [XW-1:0]   x,
	output logic [XW/2-1:0] root
);
	localparam int RW = XW / 2;

	logic [XW-1:0] xr_s  [RW];
	logic [RW-1:0] rt_s  [RW];
	logic [RW:0]   rem_s [RW];

	for (genvar k = 0; k < RW; k++) begin : g_stage
		logic [XW-1:0] x_in;
		logic [RW-1:0] rt_in;
		logic [RW:0]   rem_in;
		logic [RW+2:0] cur;
		logic [RW+2:0] trial;
		logic [RW+2:0] diff;
		logic          take;

		if (k == 0) begin : g_first
			assign x_in   = x;
			assign rt_in  = '0;
			assign rem_in = '0;
		end else begin : g_next
			assign x_in   = xr_s[k-1];
			assign rt_in  = rt_s[k-1];
			assign rem_in = rem_s[k-1];
		end

		// bring down two radicand bits, try root*4+1
		assign cur   = {rem_in, x_in[XW-1 -: 2]};
		assign trial = (RW+3)'({rt_in, 2'b01});
		assign take  = cur >= trial;
		assign diff  = cur - trial;

		always_ff @(posedge clk) begin
			if (en) begin
				xr_s[k]  <= x_in << 2;
				rt_s[k]  <= {rt_in[RW-2:0], take};
				rem_s[k] <= take ? diff[RW:0] : cur[RW:0];
			end
		end
	end

	assign root = rt_s[RW-1];
endmodule

// ===== hw/rtl/rsi_div.sv =====
// Pipelined restoring divider, one quotient bit per stage
module rsi_div import rsi_pkg::*; #(
	parameter int DW = 64
) (
	input  logic          clk,
	input  logic          en,
	input  logic [DW-1:0] rem0,
	input  dist_t         lo,
	input  logic [DW-1:0] dvs,
	output dist_t         quo
);
	localparam int QW = DIST_BITS;

	logic [DW-1:0] rem_s [QW];
	logic [DW-1:0] dv_s  [QW];
	dist_t         lo_s  [QW];
	dist_t         q_s   [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [DW-1:0] rem_in;
		logic [DW-1:0] dv_in;
		dist_t         lo_in;
		dist_t         q_in;
		logic [DW:0]   cur;
		logic [DW:0]   diff;
		logic          take;

		if (k == 0) begin : g_first
			assign rem_in = rem0;
			assign dv_in  = dvs;
			assign lo_in  = lo;
			assign q_in   = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign dv_in  = dv_s[k-1];
			assign lo_in  = lo_s[k-1];
			assign q_in   = q_s[k-1];
		end

		assign cur  = {rem_in, lo_in[QW-1]};
		assign take = cur >= {1'b0, dv_in};
		assign diff = cur - {1'b0, dv_in};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= take ? diff[DW-1:0] : cur[DW-1:0];
				dv_s[k]  <= dv_in;
				lo_s[k]  <= {lo_in[QW-2:0], 1'b0};
				q_s[k]   <= {q_in[QW-2:0], take};
			end
		end
	end

	assign quo = q_s[QW-1];
endmodule
